// ===== rtl/dcra_pkg.sv =====
package dcra_pkg;

   // Node count of the causal graph; action rules shift z past the observed nodes
   localparam int NODE_COUNT = 16;

   localparam int SET_W = 16;
   localparam int OP_W = 5;
   localparam int SEP_W = 32;
   localparam int CSR_IDX_W = 2;

   // Rule codes
   localparam logic signed [OP_W-1:0] OP_OBS_ADD   = 5'sd1;
   localparam logic signed [OP_W-1:0] OP_OBS_DEL   = -5'sd1;
   localparam logic signed [OP_W-1:0] OP_ACT_ADD   = 5'sd2;
   localparam logic signed [OP_W-1:0] OP_ACT_DEL   = -5'sd2;
   localparam logic signed [OP_W-1:0] OP_DO_ADD    = 5'sd3;
   localparam logic signed [OP_W-1:0] OP_DO_DEL    = -5'sd3;
   localparam logic signed [OP_W-1:0] OP_MARGIN    = 5'sd4;
   localparam logic signed [OP_W-1:0] OP_CONDITION = 5'sd5;
   localparam logic signed [OP_W-1:0] OP_BAYES_FWD = 5'sd6;
   localparam logic signed [OP_W-1:0] OP_BAYES_REV = -5'sd6;
   localparam logic signed [OP_W-1:0] OP_CHAIN_FWD = 5'sd7;
   localparam logic signed [OP_W-1:0] OP_CHAIN_REV = -5'sd7;
   localparam logic signed [OP_W-1:0] OP_JOINT_FWD = 5'sd8;
   localparam logic signed [OP_W-1:0] OP_JOINT_REV = -5'sd8;
   localparam logic signed [OP_W-1:0] OP_SWITCH_EN = 5'sd9;
   localparam logic signed [OP_W-1:0] OP_PROXY_SUB = 5'sd10;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROXY_MASK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_MASK  = 2'd2;

   typedef struct packed {
      logic [SET_W-1:0] switch_mask;
      logic [SET_W-1:0] proxy_mask;
      logic [SET_W-1:0] fixed_node_mask;
   } dcra_masks_type;

   typedef struct packed {
      logic signed [OP_W-1:0] operation;
      logic [SET_W-1:0]       outcome_set;
      logic [SET_W-1:0]       cond_set;
      logic [SET_W-1:0]       action_set;
      logic [SET_W-1:0]       enabled_set;
      logic [SET_W-1:0]       rule_set;
   } dcra_request_type;

   typedef struct packed {
      logic             valid_res;
      logic [SET_W-1:0] new_outcome;
      logic [SET_W-1:0] new_cond;
      logic [SET_W-1:0] new_action;
      logic [SET_W-1:0] new_enabled;
      logic [SET_W-1:0] req_outcome;
      logic [SET_W-1:0] req_cond;
      logic [SET_W-1:0] req_enabled;
      logic             needs_enumerate;
      logic [SEP_W-1:0] sep_second;
      logic [SET_W-1:0] sep_given;
      logic [SET_W-1:0] sep_acted;
   } dcra_result_type;

endpackage

// ===== rtl/dcra_rule_eval.sv =====
module dcra_rule_eval (
   input  dcra_pkg::dcra_request_type request,
   input  dcra_pkg::dcra_masks_type   masks,
   output dcra_pkg::dcra_result_type  result
);

   logic signed [dcra_pkg::OP_W-1:0] op;
   logic [dcra_pkg::SET_W-1:0] y, xw, x, d, z, w, tmask, pm, fx, sm;
   logic [dcra_pkg::SET_W-1:0] vy, vx, u, v, ey, ex, sw;
   logic [dcra_pkg::SEP_W-1:0] z_wide, z_shift;
   logic md, clash, ok;

   assign op = request.operation;
   assign y  = request.outcome_set;
   assign xw = request.cond_set;
   assign x  = request.action_set;
   assign d  = request.enabled_set;
   assign z  = request.rule_set;
   assign sm = masks.switch_mask;
   assign pm = masks.proxy_mask;
   assign fx = masks.fixed_node_mask;

   // Observed part of the conditioning set and true-variable mask
   assign w     = xw & ~x;
   assign md    = |sm;
   assign tmask = sm >> 1;

   // Refuse z when it would mix a variable with its proxy
   assign clash = (|((((y | xw) & pm) >> 2) & z)) ||
                  (|((((y | xw) & tmask) << 2) & z)) ||
                  (|(((z & pm) >> 2) & z)) ||
                  (|(((z & tmask) << 2) & z));

   // Proxy substitution terms
   assign vy = y & z;
   assign vx = xw & z;
   assign u  = y & pm & z;
   assign v  = xw & pm & z;
   assign ey = y & d;
   assign ex = xw & d;
   assign sw = (y | w) & sm;

   // Action rules place z above the observed nodes in the query
   assign z_wide  = {{(dcra_pkg::SEP_W - dcra_pkg::SET_W){1'b0}}, z};
   assign z_shift = z_wide << dcra_pkg::NODE_COUNT;

   // Admissibility test per rule
   always_comb begin
      case (op)
         dcra_pkg::OP_OBS_ADD, dcra_pkg::OP_BAYES_REV: begin
            ok = !(|(z & y)) && !(|(z & xw)) && !(md && clash) &&
                 !((op == dcra_pkg::OP_BAYES_REV) && (|(z & fx)));
         end
         dcra_pkg::OP_OBS_DEL: begin
            ok = !(|(z & y)) && !(|(z & x)) && ((z & w) == z);
         end
         dcra_pkg::OP_ACT_DEL, dcra_pkg::OP_DO_DEL: begin
            ok = !(|(z & y)) && !(|(z & w)) && ((z & x) == z) && !(|(z & pm));
         end
         dcra_pkg::OP_ACT_ADD: begin
            ok = !(|(z & y)) && !(|(z & x)) && ((z & xw) == z) &&
                 !(|(z & pm)) && !(|(z & fx));
         end
         dcra_pkg::OP_DO_ADD: begin
            ok = !(|(z & y)) && !(|(z & xw)) && !(|(z & fx)) &&
                 !(md && ((|(z & pm)) || clash));
         end
         dcra_pkg::OP_MARGIN: begin
            ok = ((z & y) == z) && (z != y) && !(|(z & fx)) &&
                 !(md && (|(z & y & sm)) && (|(z & d)));
         end
         dcra_pkg::OP_CONDITION: begin
            ok = ((z & y) == z) && (z != y) && !(|(z & fx)) &&
                 !(md && (|(y & sm)) && (|(y & d)));
         end
         dcra_pkg::OP_BAYES_FWD: begin
            ok = ((z & xw) == z) && !(|(z & x)) && !(|(z & fx));
         end
         dcra_pkg::OP_CHAIN_FWD, dcra_pkg::OP_CHAIN_REV: begin
            ok = ((z & y) == z) && ((z & d) == z) && !(|(z & fx)) && (z != y);
         end
         dcra_pkg::OP_JOINT_FWD: begin
            ok = !(|(z & y)) && !(|(z & xw)) && !(|(z & fx));
         end
         dcra_pkg::OP_JOINT_REV: begin
            ok = ((z & xw) == z) && !(|(z & fx));
         end
         dcra_pkg::OP_SWITCH_EN: begin
            ok = ((z & sw) == z) && !(|(z & d));
         end
         dcra_pkg::OP_PROXY_SUB: begin
            ok = ((z & ((y | xw) & pm)) == z) &&
                 ((((ey | ex) << 1) & u) == u) &&
                 (((ex << 1) & v) == v);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // Derived term, second term and separation query
   always_comb begin
      result = '0;
      if (ok) begin
         result.valid_res   = 1'b1;
         result.new_outcome = y;
         result.new_cond    = xw;
         result.new_action  = x;
         result.new_enabled = d;
         case (op)
            dcra_pkg::OP_OBS_ADD: begin
               result.new_cond   = xw | z;
               result.sep_second = z_wide;
               result.sep_given  = xw;
               result.sep_acted  = x;
            end
            dcra_pkg::OP_OBS_DEL: begin
               result.new_cond    = xw & ~z;
               result.new_enabled = d & ~z;
               result.sep_second  = z_wide;
               result.sep_given   = xw & ~z;
               result.sep_acted   = x;
            end
            dcra_pkg::OP_ACT_ADD: begin
               result.new_action  = x | z;
               result.new_enabled = d | (z & sm);
               result.sep_second  = z_shift;
               result.sep_given   = xw;
               result.sep_acted   = x;
            end
            dcra_pkg::OP_ACT_DEL: begin
               result.new_action = x & ~z;
               result.sep_second = z_shift;
               result.sep_given  = xw;
               result.sep_acted  = x & ~z;
            end
            dcra_pkg::OP_DO_ADD: begin
               result.new_cond    = xw | z;
               result.new_action  = x | z;
               result.new_enabled = d | (z & sm);
               result.sep_second  = z_shift;
               result.sep_given   = xw;
               result.sep_acted   = x;
            end
            dcra_pkg::OP_DO_DEL: begin
               result.new_cond    = xw & ~z;
               result.new_action  = x & ~z;
               result.new_enabled = d & ~z;
               result.sep_second  = z_shift;
               result.sep_given   = xw & ~z;
               result.sep_acted   = x & ~z;
            end
            dcra_pkg::OP_MARGIN: begin
               result.new_outcome = y & ~z;
            end
            dcra_pkg::OP_CONDITION: begin
               result.new_outcome = y & ~z;
               result.new_cond    = xw | z;
            end
            dcra_pkg::OP_BAYES_FWD: begin
               result.new_outcome = y | z;
               result.new_cond    = xw & ~z;
               result.req_outcome = z;
               result.req_cond    = xw & ~z;
               result.req_enabled = d & ~y;
            end
            dcra_pkg::OP_BAYES_REV: begin
               result.new_outcome     = y | z;
               result.req_outcome     = z;
               result.req_cond        = xw | y;
               result.req_enabled     = d;
               result.needs_enumerate = 1'b1;
            end
            dcra_pkg::OP_CHAIN_FWD: begin
               result.new_outcome = y & ~z;
               result.new_cond    = xw | z;
               result.req_outcome = z;
               result.req_cond    = xw;
               result.req_enabled = d & (xw | z);
            end
            dcra_pkg::OP_CHAIN_REV: begin
               result.new_outcome = y & ~z;
               result.new_enabled = d & ~z;
               result.req_outcome = z;
               result.req_cond    = xw | (y & ~z);
               result.req_enabled = d;
            end
            dcra_pkg::OP_JOINT_FWD: begin
               result.new_outcome     = z;
               result.new_cond        = xw | y;
               result.req_outcome     = y | z;
               result.req_cond        = xw;
               result.req_enabled     = d;
               result.needs_enumerate = 1'b1;
            end
            dcra_pkg::OP_JOINT_REV: begin
               result.new_outcome     = z;
               result.new_cond        = xw & ~z;
               result.new_enabled     = d & ~y;
               result.req_outcome     = y | z;
               result.req_cond        = xw & ~z;
               result.req_enabled     = d;
               result.needs_enumerate = 1'b1;
            end
            dcra_pkg::OP_SWITCH_EN: begin
               result.new_enabled = d | z;
            end
            dcra_pkg::OP_PROXY_SUB: begin
               result.new_outcome = (y & ~vy) | (vy >> 2);
               result.new_cond    = (xw & ~vx) | (vx >> 2);
            end
            default: begin
               result = '0;
            end
         endcase
      end
   end

endmodule

// ===== rtl/do_calculus_rule_apply_core.sv =====
// A taken request is registered in request_ff, evaluated combinationally, and its result
// is registered in result_ff, with the result strobe registered alongside it.
// Throughput: one request per cycle; busy is always low since the receiver never stalls.
// Each request yields exactly one result, shown for one cycle with rsp_valid high.
// Synchronous reset clears the pipeline valids and sets all three masks to zero.
module do_calculus_rule_apply_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [dcra_pkg::OP_W-1:0]  req_operation,
   input  logic [dcra_pkg::SET_W-1:0]        req_outcome_set,
   input  logic [dcra_pkg::SET_W-1:0]        req_cond_set,
   input  logic [dcra_pkg::SET_W-1:0]        req_action_set,
   input  logic [dcra_pkg::SET_W-1:0]        req_enabled_set,
   input  logic [dcra_pkg::SET_W-1:0]        req_rule_set,
   output logic                              rsp_valid,
   output logic                              rsp_valid_res,
   output logic [dcra_pkg::SET_W-1:0]        rsp_new_outcome,
   output logic [dcra_pkg::SET_W-1:0]        rsp_new_cond,
   output logic [dcra_pkg::SET_W-1:0]        rsp_new_action,
   output logic [dcra_pkg::SET_W-1:0]        rsp_new_enabled,
   output logic [dcra_pkg::SET_W-1:0]        rsp_req_outcome,
   output logic [dcra_pkg::SET_W-1:0]        rsp_req_cond,
   output logic [dcra_pkg::SET_W-1:0]        rsp_req_enabled,
   output logic                              rsp_needs_enumerate,
   output logic [dcra_pkg::SEP_W-1:0]        rsp_sep_second,
   output logic [dcra_pkg::SET_W-1:0]        rsp_sep_given,
   output logic [dcra_pkg::SET_W-1:0]        rsp_sep_acted,
   input  logic                              csr_write_en,
   input  logic [dcra_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dcra_pkg::SET_W-1:0]        csr_wdata
);

   dcra_pkg::dcra_masks_type   masks_ff, masks_in;
   dcra_pkg::dcra_request_type request_ff, request_in;
   dcra_pkg::dcra_result_type  result_ff, result_in;
   logic                       stage_vld_ff, stage_vld_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic                       accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Decode mask register writes
   always_comb begin
      masks_in = masks_ff;
      if (csr_write_en) begin
         case (csr_index)
            dcra_pkg::CSR_SWITCH_MASK: masks_in.switch_mask     = csr_wdata;
            dcra_pkg::CSR_PROXY_MASK:  masks_in.proxy_mask      = csr_wdata;
            dcra_pkg::CSR_FIXED_MASK:  masks_in.fixed_node_mask = csr_wdata;
            default:                   masks_in = masks_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         masks_ff <= '0;
      end else begin
         masks_ff <= masks_in;
      end
   end

   // Capture the request
   always_comb begin
      request_in.operation   = req_operation;
      request_in.outcome_set = req_outcome_set;
      request_in.cond_set    = req_cond_set;
      request_in.action_set  = req_action_set;
      request_in.enabled_set = req_enabled_set;
      request_in.rule_set    = req_rule_set;
   end

   assign stage_vld_in = accept;
   assign rsp_vld_in   = stage_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         request_ff <= request_in;
      end
   end

   // Apply the rule
   dcra_rule_eval u_rule_eval (
      .request (request_ff),
      .masks   (masks_ff),
      .result  (result_in)
   );

   // Hold the result for its strobe cycle
   always_ff @(posedge clock) begin
      if (stage_vld_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_valid_res       = result_ff.valid_res;
   assign rsp_new_outcome     = result_ff.new_outcome;
   assign rsp_new_cond        = result_ff.new_cond;
   assign rsp_new_action      = result_ff.new_action;
   assign rsp_new_enabled     = result_ff.new_enabled;
   assign rsp_req_outcome     = result_ff.req_outcome;
   assign rsp_req_cond        = result_ff.req_cond;
   assign rsp_req_enabled     = result_ff.req_enabled;
   assign rsp_needs_enumerate = result_ff.needs_enumerate;
   assign rsp_sep_second      = result_ff.sep_second;
   assign rsp_sep_given       = result_ff.sep_given;
   assign rsp_sep_acted       = result_ff.sep_acted;

   // Every accepted request comes out as a result strobe after the request and result registers
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("request did not produce a result");

   // No result without an accepted request ahead of it in the pipeline
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ##1 !rsp_valid)
      else $error("result without request");

   // A refused rule gives an all-zero result
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |->
         (rsp_new_outcome == '0 && rsp_new_cond == '0 && rsp_new_action == '0 &&
          rsp_new_enabled == '0 && rsp_req_outcome == '0 && rsp_sep_second == '0 &&
          rsp_sep_given == '0 && rsp_sep_acted == '0 && !rsp_needs_enumerate))
      else $error("refused rule has nonzero fields");

   // Enumeration only accompanies a second term
   a_enum_needs_term: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_needs_enumerate) |-> rsp_valid_res)
      else $error("enumerate flag on refused rule");

endmodule

// ===== tb/dcra_checker.sv =====
`timescale 1ns / 1ps

module dcra_checker
   import dcra_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic signed [OP_W-1:0]    req_operation,
   input  logic [SET_W-1:0]          req_outcome_set,
   input  logic [SET_W-1:0]          req_cond_set,
   input  logic [SET_W-1:0]          req_action_set,
   input  logic [SET_W-1:0]          req_enabled_set,
   input  logic [SET_W-1:0]          req_rule_set,
   input  logic                      rsp_valid,
   input  logic                      rsp_valid_res,
   input  logic [SET_W-1:0]          rsp_new_outcome,
   input  logic [SET_W-1:0]          rsp_new_cond,
   input  logic [SET_W-1:0]          rsp_new_action,
   input  logic [SET_W-1:0]          rsp_new_enabled,
   input  logic [SET_W-1:0]          rsp_req_outcome,
   input  logic [SET_W-1:0]          rsp_req_cond,
   input  logic [SET_W-1:0]          rsp_req_enabled,
   input  logic                      rsp_needs_enumerate,
   input  logic [SEP_W-1:0]          rsp_sep_second,
   input  logic [SET_W-1:0]          rsp_sep_given,
   input  logic [SET_W-1:0]          rsp_sep_acted,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [SET_W-1:0]          csr_wdata,
   output int                        error_count,
   output int                        pending_count,
   output int                        result_count
);

   // Local copy of the mask registers
   logic [SET_W-1:0] switch_bits;
   logic [SET_W-1:0] proxy_bits;
   logic [SET_W-1:0] fixed_bits;

   dcra_result_type derived_terms_q[$];
   int mismatches   = 0;
   int results_seen = 0;

   // True when z would pair a variable with its proxy, directly or through the term
   function automatic logic missing_clash(logic [SET_W-1:0] y, logic [SET_W-1:0] xw,
                                          logic [SET_W-1:0] z, logic [SET_W-1:0] tmask);
      logic [SET_W-1:0] present;
      present = y | xw;
      if ((((present & proxy_bits) >> 2) & z) != '0) return 1'b1;
      if ((((present & tmask) << 2) & z) != '0) return 1'b1;
      if ((((z & proxy_bits) >> 2) & z) != '0) return 1'b1;
      if ((((z & tmask) << 2) & z) != '0) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic rule_admissible(logic signed [OP_W-1:0] op,
                                            logic [SET_W-1:0] y, logic [SET_W-1:0] xw,
                                            logic [SET_W-1:0] x, logic [SET_W-1:0] d,
                                            logic [SET_W-1:0] z);
      logic             md;
      logic [SET_W-1:0] tmask;
      logic [SET_W-1:0] w;
      logic [SET_W-1:0] sw_vars;
      logic [SET_W-1:0] u;
      logic [SET_W-1:0] v;
      logic [SET_W-1:0] ey;
      logic [SET_W-1:0] ex;
      md    = (switch_bits != '0);
      tmask = switch_bits >> 1;
      w     = xw & ~x;
      case (op)
         OP_OBS_ADD: begin
            if (((z & y) != '0) || ((z & xw) != '0)) return 1'b0;
            if (md && missing_clash(y, xw, z, tmask)) return 1'b0;
            return 1'b1;
         end
         OP_OBS_DEL:
            return ((z & y) == '0) && ((z & x) == '0) && ((z & w) == z);
         OP_ACT_DEL, OP_DO_DEL:
            return ((z & y) == '0) && ((z & w) == '0) && ((z & x) == z)
                   && ((z & proxy_bits) == '0);
         OP_ACT_ADD:
            return ((z & y) == '0) && ((z & x) == '0) && ((z & xw) == z)
                   && ((z & proxy_bits) == '0) && ((z & fixed_bits) == '0);
         OP_DO_ADD: begin
            if (((z & y) != '0) || ((z & xw) != '0) || ((z & fixed_bits) != '0))
               return 1'b0;
            if (md) begin
               if ((z & proxy_bits) != '0) return 1'b0;
               if (missing_clash(y, xw, z, tmask)) return 1'b0;
            end
            return 1'b1;
         end
         OP_MARGIN: begin
            if (((z & y) != z) || (z == y) || ((z & fixed_bits) != '0)) return 1'b0;
            if (md && ((z & y & switch_bits) != '0) && ((z & d) != '0)) return 1'b0;
            return 1'b1;
         end
         OP_CONDITION: begin
            if (((z & y) != z) || (z == y) || ((z & fixed_bits) != '0)) return 1'b0;
            if (md && ((y & switch_bits) != '0) && ((y & d) != '0)) return 1'b0;
            return 1'b1;
         end
         OP_BAYES_FWD:
            return ((z & xw) == z) && ((z & x) == '0) && ((z & fixed_bits) == '0);
         OP_BAYES_REV: begin
            if (((z & y) != '0) || ((z & xw) != '0) || ((z & fixed_bits) != '0))
               return 1'b0;
            if (md && missing_clash(y, xw, z, tmask)) return 1'b0;
            return 1'b1;
         end
         OP_CHAIN_FWD, OP_CHAIN_REV:
            return ((z & y) == z) && ((z & d) == z) && ((z & fixed_bits) == '0) && (z != y);
         OP_JOINT_FWD:
            return ((z & y) == '0) && ((z & xw) == '0) && ((z & fixed_bits) == '0);
         OP_JOINT_REV:
            return ((z & xw) == z) && ((z & fixed_bits) == '0);
         OP_SWITCH_EN: begin
            sw_vars = (y | w) & switch_bits;
            return ((z & sw_vars) == z) && ((z & d) == '0);
         end
         OP_PROXY_SUB: begin
            u = y & proxy_bits;
            v = xw & proxy_bits;
            if ((z & (u | v)) != z) return 1'b0;
            u  = u & z;
            v  = v & z;
            ey = y & d;
            ex = xw & d;
            if ((((ey | ex) << 1) & u) != u) return 1'b0;
            if (((ex << 1) & v) != v) return 1'b0;
            return 1'b1;
         end
         default:
            return 1'b0;
      endcase
   endfunction

   // Derive the rewritten term, the second term and the separation query
   function automatic dcra_result_type derive_term(logic signed [OP_W-1:0] op,
                                                   logic [SET_W-1:0] y, logic [SET_W-1:0] xw,
                                                   logic [SET_W-1:0] x, logic [SET_W-1:0] d,
                                                   logic [SET_W-1:0] z);
      dcra_result_type  r;
      logic [SEP_W-1:0] zw;
      logic [SEP_W-1:0] zs;
      logic [SET_W-1:0] vy;
      logic [SET_W-1:0] vx;
      r  = '0;
      zw = {{(SEP_W-SET_W){1'b0}}, z};
      zs = zw << NODE_COUNT;
      if (rule_admissible(op, y, xw, x, d, z)) begin
         r.valid_res   = 1'b1;
         r.new_outcome = y;
         r.new_cond    = xw;
         r.new_action  = x;
         r.new_enabled = d;
         case (op)
            OP_OBS_ADD: begin
               r.new_cond   = xw | z;
               r.sep_second = zw;
               r.sep_given  = xw;
               r.sep_acted  = x;
            end
            OP_OBS_DEL: begin
               r.new_cond    = xw & ~z;
               r.new_enabled = d & ~z;
               r.sep_second  = zw;
               r.sep_given   = xw & ~z;
               r.sep_acted   = x;
            end
            OP_ACT_ADD: begin
               r.new_action  = x | z;
               r.new_enabled = d | (z & switch_bits);
               r.sep_second  = zs;
               r.sep_given   = xw;
               r.sep_acted   = x;
            end
            OP_ACT_DEL: begin
               r.new_action = x & ~z;
               r.sep_second = zs;
               r.sep_given  = xw;
               r.sep_acted  = x & ~z;
            end
            OP_DO_ADD: begin
               r.new_cond    = xw | z;
               r.new_action  = x | z;
               r.new_enabled = d | (z & switch_bits);
               r.sep_second  = zs;
               r.sep_given   = xw;
               r.sep_acted   = x;
            end
            OP_DO_DEL: begin
               r.new_cond    = xw & ~z;
               r.new_action  = x & ~z;
               r.new_enabled = d & ~z;
               r.sep_second  = zs;
               r.sep_given   = xw & ~z;
               r.sep_acted   = x & ~z;
            end
            OP_MARGIN:
               r.new_outcome = y & ~z;
            OP_CONDITION: begin
               r.new_outcome = y & ~z;
               r.new_cond    = xw | z;
            end
            OP_BAYES_FWD: begin
               r.new_outcome = y | z;
               r.new_cond    = xw & ~z;
               r.req_outcome = z;
               r.req_cond    = xw & ~z;
               r.req_enabled = d & ~y;
            end
            OP_BAYES_REV: begin
               r.new_outcome     = y | z;
               r.req_outcome     = z;
               r.req_cond        = xw | y;
               r.req_enabled     = d;
               r.needs_enumerate = 1'b1;
            end
            OP_CHAIN_FWD: begin
               r.new_outcome = y & ~z;
               r.new_cond    = xw | z;
               r.req_outcome = z;
               r.req_cond    = xw;
               r.req_enabled = d & (xw | z);
            end
            OP_CHAIN_REV: begin
               r.new_outcome = y & ~z;
               r.new_enabled = d & ~z;
               r.req_outcome = z;
               r.req_cond    = xw | (y & ~z);
               r.req_enabled = d;
            end
            OP_JOINT_FWD: begin
               r.new_outcome     = z;
               r.new_cond        = xw | y;
               r.req_outcome     = y | z;
               r.req_cond        = xw;
               r.req_enabled     = d;
               r.needs_enumerate = 1'b1;
            end
            OP_JOINT_REV: begin
               r.new_outcome     = z;
               r.new_cond        = xw & ~z;
               r.new_enabled     = d & ~y;
               r.req_outcome     = y | z;
               r.req_cond        = xw & ~z;
               r.req_enabled     = d;
               r.needs_enumerate = 1'b1;
            end
            OP_SWITCH_EN:
               r.new_enabled = d | z;
            OP_PROXY_SUB: begin
               vy = y & z;
               vx = xw & z;
               r.new_outcome = (y & ~vy) | (vy >> 2);
               r.new_cond    = (xw & ~vx) | (vx >> 2);
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [SEP_W-1:0] want, logic [SEP_W-1:0] got);
      if (want !== got) begin
         $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Track mask writes, compare each result, queue each accepted request
   always @(posedge clock) begin
      dcra_result_type want;
      if (reset) begin
         switch_bits = '0;
         proxy_bits  = '0;
         fixed_bits  = '0;
         derived_terms_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SWITCH_MASK: switch_bits = csr_wdata;
               CSR_PROXY_MASK:  proxy_bits  = csr_wdata;
               CSR_FIXED_MASK:  fixed_bits  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            results_seen++;
            if (derived_terms_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual valid_res %b",
                        $time, rsp_valid_res);
               mismatches++;
            end else begin
               want = derived_terms_q.pop_front();
               check_field("valid_res", SEP_W'(want.valid_res), SEP_W'(rsp_valid_res));
               check_field("new_outcome", SEP_W'(want.new_outcome),
                           SEP_W'(rsp_new_outcome));
               check_field("new_cond", SEP_W'(want.new_cond), SEP_W'(rsp_new_cond));
               check_field("new_action", SEP_W'(want.new_action), SEP_W'(rsp_new_action));
               check_field("new_enabled", SEP_W'(want.new_enabled),
                           SEP_W'(rsp_new_enabled));
               check_field("req_outcome", SEP_W'(want.req_outcome),
                           SEP_W'(rsp_req_outcome));
               check_field("req_cond", SEP_W'(want.req_cond), SEP_W'(rsp_req_cond));
               check_field("req_enabled", SEP_W'(want.req_enabled),
                           SEP_W'(rsp_req_enabled));
               check_field("needs_enumerate", SEP_W'(want.needs_enumerate),
                           SEP_W'(rsp_needs_enumerate));
               check_field("sep_second", want.sep_second, rsp_sep_second);
               check_field("sep_given", SEP_W'(want.sep_given), SEP_W'(rsp_sep_given));
               check_field("sep_acted", SEP_W'(want.sep_acted), SEP_W'(rsp_sep_acted));
            end
         end
         if (start && !busy)
            derived_terms_q = {derived_terms_q,
                               derive_term(req_operation, req_outcome_set,
                                           req_cond_set, req_action_set,
                                           req_enabled_set, req_rule_set)};
      end
      error_count   <= mismatches;
      pending_count <= derived_terms_q.size();
      result_count  <= results_seen;
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import dcra_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 190;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [OP_W-1:0] RULE_OPS [16] = '{
      OP_OBS_ADD, OP_OBS_DEL, OP_ACT_ADD, OP_ACT_DEL, OP_DO_ADD, OP_DO_DEL,
      OP_MARGIN, OP_CONDITION, OP_BAYES_FWD, OP_BAYES_REV, OP_CHAIN_FWD,
      OP_CHAIN_REV, OP_JOINT_FWD, OP_JOINT_REV, OP_SWITCH_EN, OP_PROXY_SUB
   };
   localparam logic signed [OP_W-1:0] UNKNOWN_OPS [8] = '{
      5'sd0, -5'sd4, -5'sd5, -5'sd9, -5'sd10, 5'sd11, 5'sd15, -5'sd15
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic signed [OP_W-1:0] req_operation;
   logic [SET_W-1:0]       req_outcome_set;
   logic [SET_W-1:0]       req_cond_set;
   logic [SET_W-1:0]       req_action_set;
   logic [SET_W-1:0]       req_enabled_set;
   logic [SET_W-1:0]       req_rule_set;
   logic                   rsp_valid;
   logic                   rsp_valid_res;
   logic [SET_W-1:0]       rsp_new_outcome;
   logic [SET_W-1:0]       rsp_new_cond;
   logic [SET_W-1:0]       rsp_new_action;
   logic [SET_W-1:0]       rsp_new_enabled;
   logic [SET_W-1:0]       rsp_req_outcome;
   logic [SET_W-1:0]       rsp_req_cond;
   logic [SET_W-1:0]       rsp_req_enabled;
   logic                   rsp_needs_enumerate;
   logic [SEP_W-1:0]       rsp_sep_second;
   logic [SET_W-1:0]       rsp_sep_given;
   logic [SET_W-1:0]       rsp_sep_acted;
   logic                   csr_write_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [SET_W-1:0]       csr_wdata;

   int error_count;
   int pending_count;
   int result_count;
   int cycle_count = 0;
   int requests_sent;
   int mask_settings;

   // Mask values in force, used only to shape the stimulus
   logic [SET_W-1:0] cur_switch;
   logic [SET_W-1:0] cur_proxy;
   logic [SET_W-1:0] cur_fixed;

   do_calculus_rule_apply_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_outcome_set     (req_outcome_set),
      .req_cond_set        (req_cond_set),
      .req_action_set      (req_action_set),
      .req_enabled_set     (req_enabled_set),
      .req_rule_set        (req_rule_set),
      .rsp_valid           (rsp_valid),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_new_outcome     (rsp_new_outcome),
      .rsp_new_cond        (rsp_new_cond),
      .rsp_new_action      (rsp_new_action),
      .rsp_new_enabled     (rsp_new_enabled),
      .rsp_req_outcome     (rsp_req_outcome),
      .rsp_req_cond        (rsp_req_cond),
      .rsp_req_enabled     (rsp_req_enabled),
      .rsp_needs_enumerate (rsp_needs_enumerate),
      .rsp_sep_second      (rsp_sep_second),
      .rsp_sep_given       (rsp_sep_given),
      .rsp_sep_acted       (rsp_sep_acted),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   dcra_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_outcome_set     (req_outcome_set),
      .req_cond_set        (req_cond_set),
      .req_action_set      (req_action_set),
      .req_enabled_set     (req_enabled_set),
      .req_rule_set        (req_rule_set),
      .rsp_valid           (rsp_valid),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_new_outcome     (rsp_new_outcome),
      .rsp_new_cond        (rsp_new_cond),
      .rsp_new_action      (rsp_new_action),
      .rsp_new_enabled     (rsp_new_enabled),
      .rsp_req_outcome     (rsp_req_outcome),
      .rsp_req_cond        (rsp_req_cond),
      .rsp_req_enabled     (rsp_req_enabled),
      .rsp_needs_enumerate (rsp_needs_enumerate),
      .rsp_sep_second      (rsp_sep_second),
      .rsp_sep_given       (rsp_sep_given),
      .rsp_sep_acted       (rsp_sep_acted),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .error_count         (error_count),
      .pending_count       (pending_count),
      .result_count        (result_count)
   );

   always #4 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Random set with varying bit density
   function automatic logic [SET_W-1:0] rand_set();
      case ($urandom_range(0, 3))
         0:       return SET_W'($urandom);
         1:       return SET_W'($urandom & $urandom);
         2:       return SET_W'($urandom | $urandom);
         default: return SET_W'($urandom & $urandom & $urandom);
      endcase
   endfunction

   // Drive one request at the falling edge and hold it until taken
   task automatic send_request(logic signed [OP_W-1:0] op, logic [SET_W-1:0] y,
                               logic [SET_W-1:0] xw, logic [SET_W-1:0] x,
                               logic [SET_W-1:0] d, logic [SET_W-1:0] z, bit idle_ok);
      if (idle_ok && ($urandom_range(0, 3) == 0)) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start           = 1'b1;
      req_operation   = op;
      req_outcome_set = y;
      req_cond_set    = xw;
      req_action_set  = x;
      req_enabled_set = d;
      req_rule_set    = z;
      do @(posedge clock); while (busy);
      requests_sent++;
      @(negedge clock);
   endtask

   // Build a term and, mostly, a z that the rule can accept
   task automatic shaped_request(logic signed [OP_W-1:0] op, bit shaped, bit idle_ok);
      logic [SET_W-1:0] y;
      logic [SET_W-1:0] xw;
      logic [SET_W-1:0] x;
      logic [SET_W-1:0] d;
      logic [SET_W-1:0] w;
      logic [SET_W-1:0] allow;
      logic [SET_W-1:0] z;
      y  = rand_set();
      xw = rand_set();
      x  = ($urandom_range(0, 7) != 0) ? (rand_set() & xw) : rand_set();
      d  = rand_set();
      w  = xw & ~x;
      case (op)
         OP_OBS_ADD, OP_DO_ADD, OP_BAYES_REV, OP_JOINT_FWD:
            allow = ~(y | xw) & ~cur_fixed;
         OP_OBS_DEL:
            allow = w & ~y & ~x;
         OP_ACT_DEL, OP_DO_DEL:
            allow = x & ~y & ~w & ~cur_proxy;
         OP_ACT_ADD:
            allow = w & ~y & ~cur_proxy & ~cur_fixed;
         OP_MARGIN, OP_CONDITION:
            allow = y & ~cur_fixed;
         OP_CHAIN_FWD, OP_CHAIN_REV:
            allow = y & d & ~cur_fixed;
         OP_BAYES_FWD:
            allow = w & ~cur_fixed;
         OP_JOINT_REV:
            allow = xw & ~cur_fixed;
         OP_SWITCH_EN:
            allow = (y | w) & cur_switch & ~d;
         OP_PROXY_SUB: begin
            allow = (y | xw) & cur_proxy;
            if ($urandom_range(0, 1) == 0) d = d | (allow >> 1);
         end
         default:
            allow = '1;
      endcase
      z = shaped ? (rand_set() & allow) : rand_set();
      send_request(op, y, xw, x, d, z, idle_ok);
   endtask

   // Drop start, let results drain, then give the pipeline its latency
   task automatic wait_idle();
      start = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_masks(logic [SET_W-1:0] sw, logic [SET_W-1:0] px,
                              logic [SET_W-1:0] fx);
      csr_write_en = 1'b1;
      csr_index    = CSR_SWITCH_MASK;
      csr_wdata    = sw;
      @(negedge clock);
      csr_index    = CSR_PROXY_MASK;
      csr_wdata    = px;
      @(negedge clock);
      csr_index    = CSR_FIXED_MASK;
      csr_wdata    = fx;
      @(negedge clock);
      csr_write_en = 1'b0;
      cur_switch   = sw;
      cur_proxy    = px;
      cur_fixed    = fx;
      mask_settings++;
   endtask

   initial begin
      int phase;
      int i;
      logic signed [OP_W-1:0] op;
      bit shaped;

      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = OP_OBS_ADD;
      req_outcome_set = '0;
      req_cond_set    = '0;
      req_action_set  = '0;
      req_enabled_set = '0;
      req_rule_set    = '0;
      csr_write_en    = 1'b0;
      csr_index       = CSR_SWITCH_MASK;
      csr_wdata       = '0;
      cur_switch      = '0;
      cur_proxy       = '0;
      cur_fixed       = '0;
      requests_sent   = 0;
      mask_settings   = 1;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty and full sets, every rule, the unknown codes
      send_request(OP_OBS_ADD, '0, '0, '0, '0, '0, 1'b0);
      send_request(OP_JOINT_FWD, '1, '1, '1, '1, '1, 1'b0);
      send_request(OP_JOINT_REV, '1, '1, '1, '1, '1, 1'b0);
      send_request(OP_OBS_DEL, '0, 16'h00F0, 16'h000F, '0, 16'h00FF, 1'b0);
      foreach (RULE_OPS[k]) shaped_request(RULE_OPS[k], 1'b1, 1'b0);
      foreach (UNKNOWN_OPS[k]) send_request(UNKNOWN_OPS[k], '1, '1, '0, '1, '1, 1'b0);

      // Random phases, each under its own mask setting
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_idle();
            case (phase)
               1: write_masks('1, '1, '1);
               2: write_masks('0, '0, '0);
               3: begin
                  // A write to the spare index must leave the masks alone
                  csr_write_en = 1'b1;
                  csr_index    = CSR_UNUSED;
                  csr_wdata    = '1;
                  @(negedge clock);
                  csr_write_en = 1'b0;
                  write_masks(rand_set(), rand_set(), '0);
               end
               4: write_masks(rand_set(), rand_set(), rand_set() & rand_set());
               5: write_masks('1, rand_set(), '0);
               6: write_masks(rand_set(), '1, rand_set());
               7: write_masks(16'h0001, 16'h8000, 16'h4000);
               default: write_masks(rand_set(), rand_set(), rand_set() & rand_set());
            endcase
         end
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 9) == 0) op = OP_W'($urandom_range(0, 31));
            else op = RULE_OPS[$urandom_range(0, 15)];
            shaped = ($urandom_range(0, 3) != 0);
            shaped_request(op, shaped, phase != PHASES - 1);
         end
      end

      wait_idle();
      $display("sent %0d requests over %0d mask settings, %0d results checked",
               requests_sent, mask_settings, result_count);
      $display("all rule codes, known and unknown, with shaped and free rule sets");
      if ((error_count == 0) && (pending_count == 0)) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d results never arrived", error_count, pending_count);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
